// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  // Default width of the byte offset counters.
  localparam int unsigned OFFSET_BITS_DEF = 16;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 31;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned CONT_W   = 6;

  // Output tdata: code_point, char_index, start_offset, seq_length, padded to bytes.
  localparam int unsigned RES_BITS = CP_W + INDEX_W + INDEX_W + LEN_W;
  localparam int unsigned RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [INDEX_W-1:0] char_index;
    logic [INDEX_W-1:0] start_offset;
    logic [LEN_W-1:0]   seq_length;
    logic               truncated;
    logic               string_done;
  } result_t;

  // Sequence length implied by a lead byte.
  function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    unique case (b) inside
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = 3'd1;
    endcase
    return len;
  endfunction

  // Payload bits that a lead byte keeps for a given sequence length.
  function automatic logic [BYTE_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] m;
    unique case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h7F;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/utf8d_core.sv =====
module utf8d_core
  import utf8d_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              last_in_string,
  output logic              emit,
  output result_t           result
);

  logic [LEN_W-1:0]       bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0]       sequence_len, sequence_len_next;
  logic [CP_W-1:0]        accumulator, accumulator_next;
  logic [INDEX_W-1:0]     char_counter, char_counter_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] lead_offset, lead_offset_next;

  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       rem;
  logic [CP_W-1:0]        acc;
  logic [OFFSET_BITS-1:0] lead;
  logic [LEN_W-1:0]       seq;

  // Sequence assembly: a lead byte opens a sequence, later bytes shift in six bits.
  always_comb begin
    len = lead_length(byte_value);
    if (bytes_remaining == '0) begin
      lead = byte_position;
      seq  = len;
      acc  = CP_W'(byte_value & lead_mask(len));
      rem  = len - 3'd1;
    end else begin
      lead = lead_offset;
      seq  = sequence_len;
      acc  = {accumulator[CP_W-CONT_W-1:0], byte_value[CONT_W-1:0]};
      rem  = bytes_remaining - 3'd1;
    end
  end

  // Result selection and next state.
  always_comb begin
    emit                 = 1'b0;
    result.code_point    = acc;
    result.char_index    = char_counter;
    result.start_offset  = INDEX_W'(lead);
    result.seq_length    = seq;
    result.truncated     = 1'b0;
    result.string_done   = last_in_string;
    char_counter_next    = char_counter;

    if (rem == '0) begin
      emit = 1'b1;
      if (char_counter != '1) begin
        char_counter_next = char_counter + INDEX_W'(1);
      end
    end else if (last_in_string) begin
      emit                = 1'b1;
      result.code_point   = '0;
      result.seq_length   = '0;
      result.truncated    = 1'b1;
      result.string_done  = 1'b1;
    end

    bytes_remaining_next = rem;
    sequence_len_next    = seq;
    accumulator_next     = acc;
    lead_offset_next     = lead;
    byte_position_next   = (byte_position == '1) ? byte_position
                                                  : byte_position + OFFSET_BITS'(1);

    // The last byte of a string leaves the decoder as after reset.
    if (last_in_string) begin
      bytes_remaining_next = '0;
      sequence_len_next    = '0;
      accumulator_next     = '0;
      char_counter_next    = '0;
      byte_position_next   = '0;
      lead_offset_next     = '0;
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      sequence_len    <= '0;
      accumulator     <= '0;
      char_counter    <= '0;
      byte_position   <= '0;
      lead_offset     <= '0;
    end else if (advance) begin
      bytes_remaining <= bytes_remaining_next;
      sequence_len    <= sequence_len_next;
      accumulator     <= accumulator_next;
      char_counter    <= char_counter_next;
      byte_position   <= byte_position_next;
      lead_offset     <= lead_offset_next;
    end
  end

endmodule

// ===== sv/utf8d_out_reg.sv =====
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  result_t               result,
  output logic                  space,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [RES_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  result_t held;

  // The register can take a new result when empty or when its transaction completes.
  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  // Pack the result fields, first field in the lowest bits.
  assign m_tdata = RES_DATA_W'({held.seq_length, held.start_offset,
                               held.char_index, held.code_point});
  assign m_tuser = held.truncated;
  assign m_tlast = held.string_done;

endmodule

// ===== sv/utf8_stream_decoder_top.sv =====
// A result reaches the result port through the input register and then the result register
// after the transaction of the byte that completes it is taken.
// Throughput: one byte per cycle; the input and result registers keep the stream
// moving as long as the result side takes one transaction per cycle.
// A byte that ends neither a sequence nor a string produces no result.
// Reset (rst, synchronous, active high) empties both registers and clears all state.
module utf8_stream_decoder_top
  import utf8d_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] byte_value
  input  logic                  s_tlast,   // last_in_string
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [RES_DATA_W-1:0] m_tdata,   // code_point, char_index, start_offset,
                                           // seq_length, zero padding
  output logic                  m_tuser,   // truncated
  output logic                  m_tlast    // string_done
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              emit;
  logic              space;
  logic              advance;
  result_t           result;

  // The held byte moves on unless its result would find the output register full.
  assign advance  = in_valid && (!emit || space);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  utf8d_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .byte_value    (in_byte),
    .last_in_string(in_last),
    .emit          (emit),
    .result        (result)
  );

  utf8d_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && emit),
    .result  (result),
    .space   (space),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// ===== tb/sv/utf8_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_top_tb;
  import utf8d_pkg::*;

  localparam int unsigned OFF_W = OFFSET_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [RES_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // Traffic shaping shared between the sender, the receiver and the main sequence.
  bit          idle_on;
  bit          hold_req;
  int unsigned cycle_cnt;

  // Tracks the decoder state and holds the characters still to come out.
  class utf8_scoreboard;
    result_t             expected_chars[$];
    int unsigned         errors;
    logic [LEN_W-1:0]    left_cnt;
    logic [LEN_W-1:0]    open_len;
    logic [CP_W-1:0]     acc;
    logic [INDEX_W-1:0]  chars;
    logic [OFF_W-1:0]    pos;
    logic [OFF_W-1:0]    lead_pos;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      left_cnt = '0;
      open_len = '0;
      acc      = '0;
      chars    = '0;
      pos      = '0;
      lead_pos = '0;
    endfunction

    // Sequence length from the count of leading ones of a lead byte.
    function logic [LEN_W-1:0] seq_len_of(logic [BYTE_W-1:0] b);
      if (b[7:5] == 3'b110) return 3'd2;
      if (b[7:4] == 4'b1110) return 3'd3;
      if (b[7:3] == 5'b11110) return 3'd4;
      if (b[7:2] == 6'b111110) return 3'd5;
      if (b[7:1] == 7'b1111110) return 3'd6;
      return 3'd1;
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      result_t          r;
      logic [LEN_W-1:0] len;
      logic [BYTE_W-1:0] keep;
      if (left_cnt == '0) begin
        len      = seq_len_of(b);
        keep     = 8'h7F >> ((len == 3'd1) ? 3'd0 : len);
        lead_pos = pos;
        open_len = len;
        acc      = CP_W'(b & keep);
        left_cnt = len - 3'd1;
      end else begin
        acc      = {acc[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
        left_cnt = left_cnt - 3'd1;
      end
      if (pos != '1) pos = pos + 1'b1;

      r = '0;
      if (left_cnt == '0) begin
        r.code_point   = acc;
        r.char_index   = chars;
        r.start_offset = INDEX_W'(lead_pos);
        r.seq_length   = open_len;
        r.string_done  = last;
        expected_chars.push_back(r);
        if (chars != '1) chars = chars + 1'b1;
      end else if (last) begin
        // String cut inside an open sequence.
        r.char_index   = chars;
        r.start_offset = INDEX_W'(lead_pos);
        r.truncated    = 1'b1;
        r.string_done  = 1'b1;
        expected_chars.push_back(r);
      end
      if (last) clear();
    endfunction

    function void cmp_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted result transaction.
    function void check_result(logic [RES_DATA_W-1:0] data, logic user, logic lastb);
      result_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: code_point 0x%0h", data[CP_W-1:0]);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      cmp_field("code_point", 64'(want.code_point), 64'(data[CP_W-1:0]));
      cmp_field("char_index", 64'(want.char_index), 64'(data[CP_W +: INDEX_W]));
      cmp_field("start_offset", 64'(want.start_offset),
                64'(data[CP_W+INDEX_W +: INDEX_W]));
      cmp_field("seq_length", 64'(want.seq_length), 64'(data[CP_W+2*INDEX_W +: LEN_W]));
      cmp_field("truncated", 64'(want.truncated), 64'(user));
      cmp_field("string_done", 64'(want.string_done), 64'(lastb));
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  utf8_scoreboard sb;

  utf8_stream_decoder_top #(
    .OFFSET_BITS(OFF_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("utf8_stream_decoder_top_tb NOT OK");
      $finish;
    end
  end

  // Monitor both ports; the input side is noted before the result side is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // Result side: random stall bursts, and one long hold when requested.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and wait until its transaction is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [BYTE_W-1:0] lead_byte(int len);
    case (len)
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      4:       return 8'($urandom_range(8'hF0, 8'hF7));
      5:       return 8'($urandom_range(8'hF8, 8'hFB));
      6:       return 8'($urandom_range(8'hFC, 8'hFD));
      default: return 8'($urandom_range(8'h00, 8'h7F));
    endcase
  endfunction

  // Mostly a proper continuation byte, sometimes any byte at all.
  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // One string of random characters, with noise and an occasional cut at the end.
  task automatic send_random_string(inout int unsigned sent);
    int                n_chars;
    int                len;
    bit                trunc;
    logic [BYTE_W-1:0] q[$];
    n_chars = $urandom_range(1, 12);
    trunc   = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        q.push_back(8'($urandom));
      end else begin
        len = $urandom_range(1, 6);
        q.push_back(lead_byte(len));
        repeat (len - 1) q.push_back(cont_byte());
      end
    end
    if (trunc) begin
      len = $urandom_range(2, 6);
      q.push_back(lead_byte(len));
      repeat ($urandom_range(0, len - 2)) q.push_back(cont_byte());
    end
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    sent += q.size();
  endtask

  // Main sequence.
  initial begin
    // Directed bytes as {last, byte}: ASCII extremes, stray bytes, lengths 1 to 3, 5 and 6,
    // the largest code point, an unchecked continuation and two cut strings.
    static logic [8:0] directed[$] = '{
      9'h000, 9'h07F, 9'h080, 9'h0FF, 9'h0FE,
      9'h0C0, 9'h080,
      9'h0EF, 9'h0BF, 9'h0BF,
      9'h0F8, 9'h088, 9'h080, 9'h080, 9'h080,
      9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF,
      9'h141,
      9'h0C3, 9'h041, 9'h0E2, 9'h182,
      9'h1F0
    };
    int unsigned sent;

    sb        = new();
    sent      = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    // Random strings with idling on both sides.
    while (sent < 1000) send_random_string(sent);

    // Hold the result side off while the sender keeps offering bytes.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    while (sent < 1080) send_random_string(sent);

    // Closing stretch without any idling.
    while (sent < 1350) send_random_string(sent);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("utf8_stream_decoder_top_tb OK");
    end else begin
      $display("utf8_stream_decoder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
